[hw/rtl/touch_swipe_direction_defines.svh]
// assertion macros for the swipe detector
`ifndef TOUCH_SWIPE_DIRECTION_DEFINES_SVH
`define TOUCH_SWIPE_DIRECTION_DEFINES_SVH

// condition and consequence in the same cycle
`define TSD_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("swipe detector check failed");

// consequence in the cycle after the condition
`define TSD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("swipe detector check failed");

`endif

[hw/rtl/tsd_pkg.sv]
package tsd_pkg;

	localparam int COORD_BITS = 12;
	localparam int KIND_BITS  = 3;
	localparam int VALUE_BITS = 12;
	localparam int DIR_BITS   = 3;
	localparam int LIMIT_BITS = 12;

	typedef logic [KIND_BITS-1:0]  kind_t;
	typedef logic [VALUE_BITS-1:0] value_t;
	typedef logic [DIR_BITS-1:0]   dir_t;
	typedef logic [LIMIT_BITS-1:0] limit_t;
	typedef logic [COORD_BITS-1:0] coord_t;

	localparam kind_t KIND_X        = 3'd0;
	localparam kind_t KIND_Y        = 3'd1;
	localparam kind_t KIND_PRESSURE = 3'd2;
	localparam kind_t KIND_KEY      = 3'd3;

	localparam dir_t DIR_UP    = 3'd0;
	localparam dir_t DIR_DOWN  = 3'd1;
	localparam dir_t DIR_LEFT  = 3'd2;
	localparam dir_t DIR_RIGHT = 3'd3;
	localparam dir_t DIR_QUIT  = 3'd4;

	localparam limit_t QUIT_LIMIT_RESET = 12'd480;

endpackage

[hw/rtl/tsd_event_if.sv]
interface tsd_event_if;
	logic               valid;
	logic               ready;
	tsd_pkg::kind_t     event_kind;
	tsd_pkg::value_t    event_value;

	modport source (output valid, output event_kind, output event_value, input ready);
	modport sink (input valid, input event_kind, input event_value, output ready);
endinterface

[hw/rtl/tsd_dir_if.sv]
interface tsd_dir_if;
	logic           valid;
	logic           ready;
	tsd_pkg::dir_t  direction;

	modport source (output valid, output direction, input ready);
	modport sink (input valid, input direction, output ready);
endinterface

[hw/rtl/tsd_cfg_if.sv]
interface tsd_cfg_if;
	logic             valid;
	logic             ready;
	tsd_pkg::limit_t  quit_start_limit;

	modport source (output valid, output quit_start_limit, input ready);
	modport sink (input valid, input quit_start_limit, output ready);
endinterface

[hw/rtl/touch_swipe_direction.sv]
// Swipe direction detector. Touch events (x, y, pressure, key) enter on evt, one word per
// cycle when nothing stalls; the first and latest value of each axis are tracked, and a zero
// pressure or a key release ends the gesture and emits one direction word on res (up, down,
// left, right, or quit for an upward swipe whose start y is above quit_start_limit). Each
// ending event passes the input then the result register before its direction word appears.
// Throughput is one event per cycle; the input stage stalls only when it holds an ending
// event while the result register still holds an untaken word. The user must write the quit
// limit, 480 after reset, on cfg only while no gesture word is in flight (not enforced).
`include "touch_swipe_direction_defines.svh"

module touch_swipe_direction (
	input  logic    clk,
	input  logic    arst_n,
	tsd_event_if.sink   evt,
	tsd_dir_if.source   res,
	tsd_cfg_if.sink     cfg
);
	import tsd_pkg::*;

	localparam int CMP_BITS = (COORD_BITS > LIMIT_BITS) ? COORD_BITS : LIMIT_BITS;

	logic   valid_s1;
	kind_t  kind_s1;
	value_t value_s1;

	coord_t start_x_q, start_y_q, last_x_q, last_y_q;
	logic   seen_x_q, seen_y_q;
	limit_t limit_q;

	logic   res_valid_q;
	dir_t   direction_s2;

	logic   done_s1;
	logic   adv_s1;
	logic   fire_s1;
	coord_t coord_s1;
	coord_t dx, dy;
	dir_t   dir_next;

	assign coord_s1 = COORD_BITS'(value_s1);
	assign done_s1  = ((kind_s1 == KIND_PRESSURE) || (kind_s1 == KIND_KEY)) && (value_s1 == '0);
	assign adv_s1   = !done_s1 || !res_valid_q || res.ready;
	assign fire_s1  = valid_s1 && adv_s1;
	assign evt.ready = !valid_s1 || adv_s1;
	assign cfg.ready = 1'b1;
	assign res.valid = res_valid_q;
	assign res.direction = direction_s2;

	always_comb begin
		dx = (start_x_q > last_x_q) ? (start_x_q - last_x_q) : (last_x_q - start_x_q);
		dy = (start_y_q > last_y_q) ? (start_y_q - last_y_q) : (last_y_q - start_y_q);
		if (dy > dx) begin
			if (last_y_q < start_y_q) begin
				if (CMP_BITS'(start_y_q) > CMP_BITS'(limit_q)) begin
					dir_next = DIR_QUIT;
				end else begin
					dir_next = DIR_UP;
				end
			end else begin
				dir_next = DIR_DOWN;
			end
		end else if (last_x_q < start_x_q) begin
			dir_next = DIR_LEFT;
		end else begin
			dir_next = DIR_RIGHT;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (evt.ready) begin
			valid_s1 <= evt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (evt.valid && evt.ready) begin
			kind_s1  <= evt.event_kind;
			value_s1 <= evt.event_value;
		end
	end

	// gesture state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q <= '0;
			start_y_q <= '0;
			last_x_q  <= '0;
			last_y_q  <= '0;
			seen_x_q  <= 1'b0;
			seen_y_q  <= 1'b0;
		end else if (fire_s1) begin
			if (done_s1) begin
				start_x_q <= '0;
				start_y_q <= '0;
				last_x_q  <= '0;
				last_y_q  <= '0;
				seen_x_q  <= 1'b0;
				seen_y_q  <= 1'b0;
			end else if (kind_s1 == KIND_X) begin
				if (!seen_x_q) begin
					start_x_q <= coord_s1;
				end
				seen_x_q <= 1'b1;
				last_x_q <= coord_s1;
			end else if (kind_s1 == KIND_Y) begin
				if (!seen_y_q) begin
					start_y_q <= coord_s1;
				end
				seen_y_q <= 1'b1;
				last_y_q <= coord_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= QUIT_LIMIT_RESET;
		end else if (cfg.valid && cfg.ready) begin
			limit_q <= cfg.quit_start_limit;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fire_s1 && done_s1) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && done_s1) begin
			direction_s2 <= dir_next;
		end
	end

	`TSD_ASSERT_NEXT(a_end_gives_word, fire_s1 && done_s1, res_valid_q)
	`TSD_ASSERT_NEXT(a_end_clears_state, fire_s1 && done_s1, !seen_x_q && !seen_y_q)
	`TSD_ASSERT_NOW(a_unseen_x_zero, !seen_x_q, (start_x_q == '0) && (last_x_q == '0))
	`TSD_ASSERT_NOW(a_unseen_y_zero, !seen_y_q, (start_y_q == '0) && (last_y_q == '0))

endmodule

[bench/touch_swipe_direction_checker.sv]
module touch_swipe_direction_checker (
	input  logic clk,
	input  logic arst_n,
	tsd_event_if evt,
	tsd_dir_if   res,
	tsd_cfg_if   cfg,
	output int   mismatches,
	output int   waiting,
	output int   dir_count [5]
);
	timeunit 1ns;
	timeprecision 1ps;

	import tsd_pkg::*;

	limit_t quit_limit;
	coord_t first_x, first_y, latest_x, latest_y;
	bit     got_x, got_y;
	dir_t   expected_dirs [$];
	int     fail_tally;
	int     dir_tally [5];

	function automatic dir_t swipe_dir(coord_t sx, coord_t sy, coord_t lx, coord_t ly,
			limit_t lim);
		coord_t dx, dy;
		dx = (sx > lx) ? sx - lx : lx - sx;
		dy = (sy > ly) ? sy - ly : ly - sy;
		if (dy > dx) begin
			if (ly < sy) begin
				return (sy > lim) ? DIR_QUIT : DIR_UP;
			end
			return DIR_DOWN;
		end
		return (lx < sx) ? DIR_LEFT : DIR_RIGHT;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		dir_t want;
		if (!arst_n) begin
			quit_limit = QUIT_LIMIT_RESET;
			first_x = '0;
			first_y = '0;
			latest_x = '0;
			latest_y = '0;
			got_x = 1'b0;
			got_y = 1'b0;
			expected_dirs.delete();
			fail_tally = 0;
			foreach (dir_tally[i]) dir_tally[i] = 0;
			mismatches <= 0;
			waiting <= 0;
			dir_count <= '{default: 0};
		end else begin
			// results first: a word on res always belongs to an earlier event
			if (res.valid && res.ready) begin
				if (expected_dirs.size() == 0) begin
					$display("%0t unexpected direction word: expected none, got %0d",
						$time, res.direction);
					fail_tally++;
				end else begin
					want = expected_dirs.pop_front();
					if (want <= DIR_QUIT) dir_tally[want]++;
					if (res.direction !== want) begin
						$display("%0t direction mismatch: expected %0d, got %0d",
							$time, want, res.direction);
						fail_tally++;
					end
				end
			end
			if (cfg.valid && cfg.ready) begin
				quit_limit = cfg.quit_start_limit;
			end
			if (evt.valid && evt.ready) begin
				case (evt.event_kind)
					KIND_X: begin
						if (!got_x) begin
							first_x = coord_t'(evt.event_value);
							got_x = 1'b1;
						end
						latest_x = coord_t'(evt.event_value);
					end
					KIND_Y: begin
						if (!got_y) begin
							first_y = coord_t'(evt.event_value);
							got_y = 1'b1;
						end
						latest_y = coord_t'(evt.event_value);
					end
					KIND_PRESSURE, KIND_KEY: begin
						if (evt.event_value == '0) begin
							expected_dirs.push_back(swipe_dir(first_x, first_y, latest_x,
								latest_y, quit_limit));
							first_x = '0;
							first_y = '0;
							latest_x = '0;
							latest_y = '0;
							got_x = 1'b0;
							got_y = 1'b0;
						end
					end
					default: ;
				endcase
			end
			mismatches <= fail_tally;
			waiting <= expected_dirs.size();
			dir_count <= dir_tally;
		end
	end

endmodule

[bench/touch_swipe_direction_tb.sv]
module touch_swipe_direction_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tsd_pkg::*;

	localparam kind_t KIND_OTHER = 3'd4;
	localparam kind_t KIND_LAST  = 3'd7;
	localparam value_t VALUE_MAX = '1;
	localparam int HOLD_CYCLES  = 150;

	logic clk;
	logic arst_n;
	bit   hold_req;
	bit   no_gaps;
	int   mismatches;
	int   waiting;
	int   dir_count [5];
	int   useful_words;
	int   ignored_words;
	int   limit_writes;

	tsd_event_if evt_if ();
	tsd_dir_if   res_if ();
	tsd_cfg_if   cfg_if ();

	touch_swipe_direction uut (
		.clk    (clk),
		.arst_n (arst_n),
		.evt    (evt_if),
		.res    (res_if),
		.cfg    (cfg_if)
	);

	touch_swipe_direction_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.evt        (evt_if),
		.res        (res_if),
		.cfg        (cfg_if),
		.mismatches (mismatches),
		.waiting    (waiting),
		.dir_count  (dir_count)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#(1_000_000);
		$display("touch_swipe_direction_tb: errors");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		if (no_gaps) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// downstream side: random stalls plus one long hold-off on request
	initial begin
		int stall_left;
		int hold_left;
		bit hold_taken;
		stall_left = 0;
		hold_left = 0;
		hold_taken = 1'b0;
		res_if.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (!hold_req) hold_taken = 1'b0;
			if (hold_left > 0) begin
				hold_left--;
				res_if.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				res_if.ready <= 1'b0;
			end else begin
				stall_left = pick_gap();
				if (stall_left > 0) begin
					stall_left--;
					res_if.ready <= 1'b0;
				end else begin
					res_if.ready <= 1'b1;
				end
			end
		end
	end

	task automatic send_word(kind_t kd, value_t v);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			evt_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		evt_if.valid <= 1'b1;
		evt_if.event_kind <= kd;
		evt_if.event_value <= v;
		@(posedge clk);
		while (!evt_if.ready) @(posedge clk);
		if (kd == KIND_X || kd == KIND_Y ||
				((kd == KIND_PRESSURE || kd == KIND_KEY) && v == '0)) begin
			useful_words++;
		end else begin
			ignored_words++;
		end
	endtask

	task automatic write_limit(limit_t lim);
		evt_if.valid <= 1'b0;
		@(posedge clk);
		while (waiting != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.quit_start_limit <= lim;
		@(posedge clk);
		while (!cfg_if.ready) @(posedge clk);
		cfg_if.valid <= 1'b0;
		limit_writes++;
	endtask

	function automatic value_t pick_coord();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return '0;
		if (r == 1) return VALUE_MAX;
		return value_t'($urandom_range(0, VALUE_MAX));
	endfunction

	task automatic end_word();
		send_word($urandom_range(0, 1) ? KIND_PRESSURE : KIND_KEY, '0);
	endtask

	task automatic gesture(bit well_formed);
		int n;
		int r;
		n = well_formed ? $urandom_range(1, 6) : $urandom_range(1, 4);
		repeat (n) begin
			r = $urandom_range(0, 99);
			if (!well_formed) begin
				send_word(kind_t'($urandom_range(0, KIND_LAST)),
					($urandom_range(0, 3) == 0) ? value_t'(0) : pick_coord());
			end else if (r < 44) begin
				send_word(KIND_X, pick_coord());
			end else if (r < 88) begin
				send_word(KIND_Y, pick_coord());
			end else if (r < 94) begin
				send_word($urandom_range(0, 1) ? KIND_PRESSURE : KIND_KEY,
					value_t'($urandom_range(1, VALUE_MAX)));
			end else begin
				send_word(kind_t'($urandom_range(KIND_OTHER, KIND_LAST)), pick_coord());
			end
		end
		if (well_formed) end_word();
	endtask

	initial begin
		limit_t limits [5];
		int target;
		limits = '{12'd0, 12'd4095, limit_t'($urandom_range(1, 4094)),
			limit_t'($urandom_range(1, 4094)), QUIT_LIMIT_RESET};
		useful_words = 0;
		ignored_words = 0;
		limit_writes = 0;
		hold_req <= 1'b0;
		no_gaps <= 1'b0;
		arst_n = 1'b0;
		evt_if.valid <= 1'b0;
		evt_if.event_kind <= KIND_X;
		evt_if.event_value <= '0;
		cfg_if.valid <= 1'b0;
		cfg_if.quit_start_limit <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed gestures under the reset limit
		end_word();
		send_word(KIND_X, VALUE_MAX);
		send_word(KIND_X, '0);
		send_word(KIND_KEY, '0);
		send_word(KIND_Y, VALUE_MAX);
		send_word(KIND_Y, '0);
		send_word(KIND_PRESSURE, '0);
		send_word(KIND_Y, '0);
		send_word(KIND_Y, VALUE_MAX);
		send_word(KIND_PRESSURE, VALUE_MAX);
		send_word(KIND_KEY, VALUE_MAX);
		send_word(KIND_OTHER, '0);
		send_word(KIND_LAST, '0);
		send_word(KIND_PRESSURE, '0);
		send_word(KIND_Y, value_t'(QUIT_LIMIT_RESET));
		send_word(KIND_Y, '0);
		send_word(KIND_KEY, '0);
		send_word(KIND_X, 12'd100);
		send_word(KIND_Y, value_t'(QUIT_LIMIT_RESET + 1));
		send_word(KIND_X, 12'd110);
		send_word(KIND_Y, 12'd470);
		send_word(KIND_PRESSURE, '0);
		send_word(KIND_X, 12'd10);
		send_word(KIND_Y, 12'd10);
		send_word(KIND_X, 12'd20);
		send_word(KIND_Y, 12'd20);
		send_word(KIND_KEY, '0);

		// back-to-back gestures while the result side is held off
		no_gaps <= 1'b1;
		hold_req <= 1'b1;
		target = useful_words + 60;
		while (useful_words < target) begin
			send_word(KIND_X, pick_coord());
			send_word(KIND_Y, pick_coord());
			end_word();
		end
		hold_req <= 1'b0;
		no_gaps <= 1'b0;

		foreach (limits[p]) begin
			write_limit(limits[p]);
			no_gaps <= (p == 2);
			target = useful_words + 100;
			while (useful_words < target) gesture($urandom_range(0, 9) != 0);
		end

		evt_if.valid <= 1'b0;
		@(posedge clk);
		while (waiting != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		$display("covered %0d event words (%0d ignored) over %0d limit settings",
			useful_words, ignored_words, limit_writes + 1);
		$display("directions checked: up %0d down %0d left %0d right %0d quit %0d",
			dir_count[DIR_UP], dir_count[DIR_DOWN], dir_count[DIR_LEFT],
			dir_count[DIR_RIGHT], dir_count[DIR_QUIT]);
		if (mismatches == 0 && waiting == 0) begin
			$display("touch_swipe_direction_tb: clean");
		end else begin
			$display("touch_swipe_direction_tb: errors");
		end
		$finish;
	end

endmodule
